// ----- src/status_led_blink_sequencer_defines.svh -----
// Assertion macros for the status LED blink sequencer.
// Used by status_led_blink_sequencer; expects clk_i and rst_ni in scope.
`ifndef STATUS_LED_BLINK_SEQUENCER_DEFINES_SVH
`define STATUS_LED_BLINK_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define SLBS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slbs assertion failed");
// Next-cycle implication, disabled in reset.
`define SLBS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slbs assertion failed");
`else
`define SLBS_ASSERT_IMP(name, ante, cons)
`define SLBS_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- src/slbs_pkg.sv -----
// Shared types and constants for the status LED blink sequencer.
// No dependencies.
package slbs_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned PatternW = 8;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned StateW   = 3;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TimerW-1:0]   IntervalRst  = 16'd500;
  localparam logic [PatternW-1:0] PatConfigRst = 8'd85;
  localparam logic [PatternW-1:0] PatWifiRst   = 8'd15;
  localparam logic [PatternW-1:0] PatMqttRst   = 8'd51;

  typedef enum logic [StateW-1:0] {
    ST_NORMAL = 3'd0,
    ST_CONFIG = 3'd1,
    ST_ERROR  = 3'd2,
    ST_WIFI   = 3'd3,
    ST_MQTT   = 3'd4
  } app_state_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_BLINK = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INTERVAL    = 2'd0,
    REG_PAT_CONFIG  = 2'd1,
    REG_PAT_WIFI    = 2'd2,
    REG_PAT_MQTT    = 2'd3
  } cfg_reg_e;

endpackage

// ----- src/status_led_blink_sequencer.sv -----
// Status LED blink sequencer: info blink counter and state pattern player.
// Depends on slbs_pkg and status_led_blink_sequencer_defines.svh.
//
//   port group | dir | tdata / tuser contents (lowest bit first)
//   s_axis     | in  | tdata: blink_count[7:0], app_state[10:8], zero pad; tuser: cmd
//   m_axis     | out | tdata: info_led[0], state_led[1], zero pad
//   cfg        | in  | write enable, register index, 16-bit data, no read-back
//
// One item per cycle while the output is not stalled: an item is held in the
// input register, then the counter and pattern logic updates state and loads
// the result register. Result valid is set when the item moves from the input
// register into the result register.
// Reset is asynchronous, active low; all but the payload registers reset at once.
// An output stall holds the result and, once the input register is full,
// drops s_axis_tready.
`include "status_led_blink_sequencer_defines.svh"

module status_led_blink_sequencer
  import slbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // blink_count, app_state, pad
  input  logic                s_axis_tuser,  // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // info_led, state_led, pad
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimerW-1:0]   cfg_data_i
);

  // configuration
  logic [TimerW-1:0]   interval_q;
  logic [PatternW-1:0] pat_config_q, pat_wifi_q, pat_mqtt_q;

  // input register
  logic              in_valid_q;
  logic              cmd_q;
  logic [CountW-1:0] count_q;
  logic [StateW-1:0] app_state_q;

  // sequencer state
  logic              info_on_q, info_on_d;
  logic [CountW-1:0] blinks_q, blinks_d;
  logic [TimerW-1:0] info_timer_q, info_timer_d;
  logic [TimerW-1:0] state_timer_q, state_timer_d;
  logic [StateW-1:0] seen_q, seen_d;
  logic [IndexW-1:0] index_q, index_d;
  logic              level_q, level_d;

  // result register
  logic       out_valid_q;
  logic [1:0] out_data_q;

  logic              advance;
  logic [CountW-1:0] blinks_dec;
  logic [PatternW-1:0] pat;
  logic              pat_known;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_data_q};
  assign blinks_dec    = blinks_q - CountW'(1);

  always_comb begin
    pat       = pat_config_q;
    pat_known = 1'b1;
    unique case (seen_q)
      ST_CONFIG, ST_ERROR: pat = pat_config_q;
      ST_WIFI:             pat = pat_wifi_q;
      ST_MQTT:             pat = pat_mqtt_q;
      default:             pat_known = 1'b0;
    endcase
  end

  always_comb begin
    info_on_d     = info_on_q;
    blinks_d      = blinks_q;
    info_timer_d  = info_timer_q;
    state_timer_d = state_timer_q;
    seen_d        = seen_q;
    index_d       = index_q;
    level_d       = level_q;
    if (cmd_q == CMD_BLINK) begin
      info_on_d    = 1'b1;
      blinks_d     = count_q;
      info_timer_d = interval_q;
    end else begin
      if (blinks_q != '0) begin
        if (info_timer_q[TimerW-1:1] == '0) begin
          info_timer_d = '0;
          if (info_on_q) begin
            info_on_d    = 1'b0;
            info_timer_d = interval_q;
          end else begin
            blinks_d = blinks_dec;
            if (blinks_dec != '0) begin
              info_on_d    = 1'b1;
              info_timer_d = interval_q;
            end
          end
        end else begin
          info_timer_d = info_timer_q - TimerW'(1);
        end
      end
      if (app_state_q != seen_q) begin
        state_timer_d = interval_q;
        level_d       = 1'b0;
        index_d       = '0;
        seen_d        = app_state_q;
      end else if (seen_q != ST_NORMAL) begin
        if (state_timer_q[TimerW-1:1] == '0) begin
          state_timer_d = interval_q;
          if (pat_known) begin
            level_d = pat[index_q];
            index_d = index_q + IndexW'(1);
          end
        end else begin
          state_timer_d = state_timer_q - TimerW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= IntervalRst;
      pat_config_q  <= PatConfigRst;
      pat_wifi_q    <= PatWifiRst;
      pat_mqtt_q    <= PatMqttRst;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      info_on_q     <= 1'b0;
      blinks_q      <= '0;
      info_timer_q  <= '0;
      state_timer_q <= '0;
      seen_q        <= ST_NORMAL;
      index_q       <= '0;
      level_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_INTERVAL:   interval_q   <= cfg_data_i;
          REG_PAT_CONFIG: pat_config_q <= cfg_data_i[PatternW-1:0];
          REG_PAT_WIFI:   pat_wifi_q   <= cfg_data_i[PatternW-1:0];
          REG_PAT_MQTT:   pat_mqtt_q   <= cfg_data_i[PatternW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        info_on_q     <= info_on_d;
        blinks_q      <= blinks_d;
        info_timer_q  <= info_timer_d;
        state_timer_q <= state_timer_d;
        seen_q        <= seen_d;
        index_q       <= index_d;
        level_q       <= level_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q       <= s_axis_tuser;
      count_q     <= s_axis_tdata[CountW-1:0];
      app_state_q <= s_axis_tdata[CountW+StateW-1:CountW];
    end
    if (advance) begin
      out_data_q <= {level_d, info_on_d};
    end
  end

  `SLBS_ASSERT_IMP(a_normal_dark, seen_q == ST_NORMAL, !level_q)
  `SLBS_ASSERT_NXT(a_result_loaded, advance, out_valid_q)
  `SLBS_ASSERT_NXT(a_input_held, in_valid_q && !advance, in_valid_q && $stable(cmd_q))
  `SLBS_ASSERT_IMP(a_full_stalls_input, in_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready)

endmodule

// ----- tb/status_led_blink_sequencer_tb.sv -----
// Self-checking testbench for status_led_blink_sequencer: directed and random blink
// requests and ticks, with LED levels predicted in the bench and checked per transfer.
// Depends on slbs_pkg and the RTL of status_led_blink_sequencer only.
module status_led_blink_sequencer_tb;
  import slbs_pkg::*;

  localparam logic [CountW-1:0] ErrorBlinks   = 8'd5;
  localparam logic [StateW-1:0] StUnknownLo   = 3'd5;
  localparam logic [StateW-1:0] StUnknownHi   = 3'd7;
  localparam int                WatchdogLimit = 4000;
  localparam int                DrainCycles   = 10;

  typedef struct packed {
    logic state_led;
    logic info_led;
  } led_levels_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // blink_count[7:0], app_state[10:8], pad
  logic                s_axis_tuser  = 1'b0;  // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // info_led[0], state_led[1], pad
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [TimerW-1:0]   cfg_data_i    = '0;

  // register mirror
  logic [TimerW-1:0]   interval_cfg   = IntervalRst;
  logic [PatternW-1:0] pat_config_cfg = PatConfigRst;
  logic [PatternW-1:0] pat_wifi_cfg   = PatWifiRst;
  logic [PatternW-1:0] pat_mqtt_cfg   = PatMqttRst;

  // predicted LED state
  logic                blink_lit      = 1'b0;
  logic [CountW-1:0]   blinks_pending = '0;
  logic [TimerW-1:0]   blink_timer    = '0;
  logic [TimerW-1:0]   pattern_timer  = '0;
  logic [StateW-1:0]   shown_state    = ST_NORMAL;
  logic [IndexW-1:0]   bit_pos        = '0;
  logic                pattern_level  = 1'b0;

  led_levels_t expected_leds[$];
  int send_idle_pct   = 14;
  int recv_idle_pct   = 85;
  int hold_left       = 0;
  int stall_cycles    = 0;
  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;

  status_led_blink_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_leds(input cmd_e c, input logic [CountW-1:0] n,
                              input logic [StateW-1:0] st, output led_levels_t r);
    logic [PatternW-1:0] pat;
    logic                known;
    pat   = '0;
    known = 1'b1;
    if (c == CMD_BLINK) begin
      blink_lit      = 1'b1;
      blinks_pending = n;
      blink_timer    = interval_cfg;
    end else begin
      if (blinks_pending != 0) begin
        if (blink_timer <= 1) begin
          blink_timer = '0;
          if (blink_lit) begin
            blink_lit   = 1'b0;
            blink_timer = interval_cfg;
          end else begin
            blinks_pending = blinks_pending - 1'b1;
            if (blinks_pending != 0) begin
              blink_lit   = 1'b1;
              blink_timer = interval_cfg;
            end
          end
        end else begin
          blink_timer = blink_timer - 1'b1;
        end
      end
      if (st != shown_state) begin
        pattern_timer = interval_cfg;
        pattern_level = 1'b0;
        bit_pos       = '0;
        shown_state   = st;
      end else if (shown_state != ST_NORMAL) begin
        if (pattern_timer <= 1) begin
          pattern_timer = interval_cfg;
          case (shown_state)
            ST_CONFIG, ST_ERROR: pat = pat_config_cfg;
            ST_WIFI:             pat = pat_wifi_cfg;
            ST_MQTT:             pat = pat_mqtt_cfg;
            default:             known = 1'b0;
          endcase
          if (known) begin
            pattern_level = pat[bit_pos];
            bit_pos       = bit_pos + 1'b1;
          end
        end else begin
          pattern_timer = pattern_timer - 1'b1;
        end
      end
    end
    r.info_led  = blink_lit;
    r.state_led = pattern_level;
  endtask

  task automatic send_item(input cmd_e c, input logic [CountW-1:0] n,
                           input logic [StateW-1:0] st);
    led_levels_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {5'd0, st, n};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_leds(c, n, st, r);
    expected_leds.push_back(r);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [TimerW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (r)
      REG_INTERVAL:   interval_cfg   = v;
      REG_PAT_CONFIG: pat_config_cfg = v[PatternW-1:0];
      REG_PAT_WIFI:   pat_wifi_cfg   = v[PatternW-1:0];
      REG_PAT_MQTT:   pat_mqtt_cfg   = v[PatternW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [TimerW-1:0] interval, input logic [PatternW-1:0] pc,
                           input logic [PatternW-1:0] pw, input logic [PatternW-1:0] pm);
    drain_results();
    repeat (3) @(posedge clk_i);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_PAT_CONFIG, {8'd0, pc});
    write_reg(REG_PAT_WIFI, {8'd0, pw});
    write_reg(REG_PAT_MQTT, {8'd0, pm});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic test_info_blinks();
    configure(16'd2, 8'h55, 8'h0F, 8'h33);
    send_item(CMD_BLINK, 8'd2, ST_NORMAL);
    repeat (8) send_item(CMD_TICK, 8'd0, ST_NORMAL);
    send_item(CMD_BLINK, 8'd0, StUnknownHi);
    repeat (2) send_item(CMD_TICK, 8'hFF, ST_NORMAL);
    send_item(CMD_BLINK, 8'd255, ST_NORMAL);
    send_item(CMD_TICK, 8'd0, ST_NORMAL);
    send_item(CMD_BLINK, ErrorBlinks, ST_NORMAL);
    repeat (2) send_item(CMD_TICK, 8'd0, ST_NORMAL);
  endtask

  task automatic test_state_patterns();
    repeat (3) send_item(CMD_TICK, 8'd0, ST_CONFIG);
    send_item(CMD_TICK, 8'd0, ST_ERROR);
    repeat (3) send_item(CMD_TICK, 8'd0, ST_WIFI);
    repeat (3) send_item(CMD_TICK, 8'd0, ST_MQTT);
    repeat (2) send_item(CMD_TICK, 8'd0, StUnknownLo);
    repeat (2) send_item(CMD_TICK, 8'd0, StUnknownHi);
    send_item(CMD_TICK, 8'd0, ST_NORMAL);
  endtask

  task automatic test_zero_interval();
    configure(16'd0, 8'hFF, 8'h00, 8'h5A);
    repeat (4) send_item(CMD_TICK, 8'd0, ST_CONFIG);
    send_item(CMD_BLINK, 8'd3, ST_CONFIG);
    repeat (6) send_item(CMD_TICK, 8'd0, ST_CONFIG);
  endtask

  task automatic test_long_interval();
    configure(16'hFFFF, 8'hA5, 8'h3C, 8'hC3);
    send_item(CMD_BLINK, 8'd4, ST_NORMAL);
    repeat (5) send_item(CMD_TICK, 8'd0, ST_WIFI);
    repeat (5) send_item(CMD_TICK, 8'd0, ST_MQTT);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                target;
    int                run_len;
    int                pick;
    logic [StateW-1:0] run_state;
    logic [CountW-1:0] n;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_item(cmd_e'($urandom_range(1)), 8'($urandom_range(255)),
                  3'($urandom_range(7)));
      end else begin
        run_state = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) :
                                              3'($urandom_range(5, 7));
        run_len   = $urandom_range(4, 40);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(99) < 6) begin
            pick = $urandom_range(9);
            n = (pick == 0) ? 8'd0 : (pick == 1) ? ErrorBlinks :
                (pick == 2) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
            send_item(CMD_BLINK, n, 3'($urandom_range(7)));
          end else begin
            send_item(CMD_TICK, 8'($urandom_range(255)), run_state);
          end
        end
      end
    end
  endtask

  task automatic test_backpressure();
    configure(16'd2, 8'h96, 8'h69, 8'hF0);
    hold_left = 300;
    repeat (40) send_item(CMD_TICK, 8'($urandom_range(255)), ST_WIFI);
    drain_results();
    repeat (10) send_item(CMD_TICK, 8'($urandom_range(255)), ST_MQTT);
  endtask

  always @(posedge clk_i) begin : check_results
    led_levels_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_leds.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_leds.pop_front();
        results_checked++;
        if (m_axis_tdata[0] !== want.info_led) begin
          $error("info_led: expected %0b, got %0b", want.info_led, m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[1] !== want.state_led) begin
          $error("state_led: expected %0b, got %0b", want.state_led, m_axis_tdata[1]);
          error_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 85;
    test_info_blinks();
    test_state_patterns();
    test_zero_interval();
    test_long_interval();
    configure(16'd3, 8'hFF, 8'h00, 8'h96);
    test_random_traffic(270);

    send_idle_pct = 85;
    recv_idle_pct = 14;
    configure(16'd1, 8'h00, 8'hFF, 8'($urandom_range(255)));
    test_random_traffic(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'($urandom_range(1, 6)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
    test_random_traffic(270);
    test_backpressure();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d input transfers and %0d checked results over %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("including blink requests, all app states, zero and maximum intervals, stalls.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
